### design/psed_pkg.sv
// ----------------------------------------------------------------------------
// psed_pkg: shared types for the point store distance block
// Request and status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package psed_pkg;

    // Request codes carried by req_type. Code 3 means nothing and is ignored.
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;   // capture the input transaction
        logic exec;       // append, clear or bounds check, set result status
        logic diff;       // absolute coordinate differences from read data
        logic sq_x;       // square dx
        logic sq_y;       // square dy, add, load the root unit
        logic root_step;  // one digit of the square root
        logic finish;     // load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;   // captured request is a distance query
        logic idx_bad;    // a query index is at or beyond the count
        logic root_last;  // the current root step is the final one
        logic out_free;   // the output register can take a new result
    } stat_t;

endpackage

### design/psed_ctrl.sv
// ----------------------------------------------------------------------------
// psed_ctrl: sequencing state machine
// Steps one transaction at a time through decode, then (valid query only) difference,
// squaring of dx and dy and the iterative root, then the hand-off to the output register.
// ----------------------------------------------------------------------------
module psed_ctrl
    import psed_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_query && !stat.idx_bad)
                begin
                    state_next = ST_DIFF;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIFF:   state_next = ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (stat.root_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_req = in_valid;
            end
            ST_DECODE: cmd.exec      = 1'b1;
            ST_DIFF:   cmd.diff      = 1'b1;
            ST_SQ_X:   cmd.sq_x      = 1'b1;
            ST_SQ_Y:   cmd.sq_y      = 1'b1;
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_FINISH: cmd.finish    = stat.out_free;
            default:   cmd           = '0;
        endcase
    end

    // An accepted transaction keeps the input side busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // The squaring cycles lead straight into the root unit.
    a_square_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |-> ##3 (state_reg == ST_ROOT))
        else $error("query did not reach the root unit");

    // A result is only handed over when the output register can take it.
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !stat.out_free) |=> (state_reg == ST_FINISH))
        else $error("result dropped while output busy");

endmodule

### design/psed_dp.sv
// ----------------------------------------------------------------------------
// psed_dp: point table and distance datapath
// Holds the point memory and count, the difference and squaring stage with
// one shared multiplier, a restoring digit-by-digit square root and the
// output register.
// ----------------------------------------------------------------------------
module psed_dp
    import psed_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic        [1:0]  req_type,
    input  logic signed [15:0] x_coord,
    input  logic signed [15:0] y_coord,
    input  logic        [5:0]  first_index,
    input  logic        [5:0]  second_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [24:0] distance,
    output logic        [1:0]  status,
    output logic        [6:0]  point_count,
    input  cmd_t               cmd,
    output stat_t              stat
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CB   = COORD_BITS;
    localparam int RW   = CB + 1 + FRAC_BITS;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 1;
    localparam int ITW  = $clog2(RW);
    localparam int SUMW = 2 * CB + 1;
    localparam int EXTW = (CB > 16) ? CB : 16;
    localparam int IW   = (AW > 6) ? AW : 6;
    localparam int CMPW = (CW > 6) ? CW : 6;

    // Captured transaction.
    req_t        req_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [5:0]  first_reg;
    logic [5:0]  second_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg    <= req_t'(req_type);
            x_reg      <= x_coord;
            y_reg      <= y_coord;
            first_reg  <= first_index;
            second_reg <= second_index;
        end
    end

    // Coordinates keep their low COORD_BITS bits; missing high bits read as zero.
    logic [EXTW-1:0] x_ext;
    logic [EXTW-1:0] y_ext;
    logic [CB-1:0]   x_pt;
    logic [CB-1:0]   y_pt;

    assign x_ext = EXTW'(x_reg);
    assign y_ext = EXTW'(y_reg);
    assign x_pt  = x_ext[CB-1:0];
    assign y_pt  = y_ext[CB-1:0];

    // Point count and bounds checks.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          wr_en;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    assign full    = (count_reg == CW'(MAX_POINTS));
    assign wr_en   = cmd.exec && (req_reg == REQ_APPEND) && !full;
    assign addr_a  = AW'(IW'(first_reg));
    assign addr_b  = AW'(IW'(second_reg));

    assign stat.is_query = (req_reg == REQ_QUERY);
    assign stat.idx_bad  = (CMPW'(first_reg) >= CMPW'(count_reg))
                        || (CMPW'(second_reg) >= CMPW'(count_reg));

    always_comb
    begin
        count_next = count_reg;
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.exec && (req_reg == REQ_CLEAR))
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result status of the current transaction.
    status_t res_status_reg;
    status_t res_status_next;

    always_comb
    begin
        res_status_next = STAT_OK;
        case (req_reg)
            REQ_APPEND: res_status_next = full ? STAT_FULL : STAT_OK;
            REQ_QUERY:  res_status_next = stat.idx_bad ? STAT_BAD_INDEX : STAT_OK;
            default:    res_status_next = STAT_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
        end
    end

    // Point memory: one write port, two registered read ports.
    logic [2*CB-1:0] pt_mem [MAX_POINTS];
    logic [2*CB-1:0] rd_a_reg;
    logic [2*CB-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pt_mem[count_reg[AW-1:0]] <= {x_pt, y_pt};
        end
        rd_a_reg <= pt_mem[addr_a];
        rd_b_reg <= pt_mem[addr_b];
    end

    // Absolute differences of the two points.
    logic [CB-1:0] ax;
    logic [CB-1:0] bx;
    logic [CB-1:0] ay;
    logic [CB-1:0] by;
    logic [CB:0]   diff_x;
    logic [CB:0]   diff_y;
    logic [CB:0]   abs_x;
    logic [CB:0]   abs_y;
    logic [CB-1:0] dx_reg;
    logic [CB-1:0] dy_reg;

    assign ax     = rd_a_reg[2*CB-1:CB];
    assign ay     = rd_a_reg[CB-1:0];
    assign bx     = rd_b_reg[2*CB-1:CB];
    assign by     = rd_b_reg[CB-1:0];
    assign diff_x = {ax[CB-1], ax} - {bx[CB-1], bx};
    assign diff_y = {ay[CB-1], ay} - {by[CB-1], by};
    assign abs_x  = diff_x[CB] ? (~diff_x + 1'b1) : diff_x;
    assign abs_y  = diff_y[CB] ? (~diff_y + 1'b1) : diff_y;

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= abs_x[CB-1:0];
            dy_reg <= abs_y[CB-1:0];
        end
    end

    // One multiplier squares dx, then dy; squaring dy also forms the sum.
    logic [CB-1:0]   mul_op;
    logic [2*CB-1:0] prod;
    logic [2*CB-1:0] sqx_reg;
    logic [SUMW-1:0] sum;

    assign mul_op = cmd.sq_y ? dy_reg : dx_reg;
    assign prod   = mul_op * mul_op;
    assign sum    = SUMW'(sqx_reg) + SUMW'(prod);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_x)
        begin
            sqx_reg <= prod;
        end
    end

    // Restoring square root, one result bit per step, on sum * 4^FRAC_BITS.
    logic [RADW-1:0] rad_reg;
    logic [RADW-1:0] rad_next;
    logic [REMW-1:0] rem_reg;
    logic [REMW-1:0] rem_next;
    logic [RW-1:0]   root_reg;
    logic [RW-1:0]   root_next;
    logic [ITW-1:0]  iter_reg;
    logic [ITW-1:0]  iter_next;
    logic [1:0]      pair;
    logic [REMW+1:0] rem_sh;
    logic [REMW+1:0] trial;
    logic [REMW+1:0] rem_sub;
    logic            take;

    assign pair    = rad_reg[RADW-1 -: 2];
    assign rem_sh  = {rem_reg, pair};
    assign trial   = (REMW + 2)'({root_reg, 2'b01});
    assign rem_sub = rem_sh - trial;
    assign take    = (rem_sh >= trial);

    assign stat.root_last = (iter_reg == ITW'(RW - 1));

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        if (cmd.exec)
        begin
            root_next = '0;
        end
        else if (cmd.sq_y)
        begin
            rad_next  = RADW'(sum) << (2 * FRAC_BITS);
            rem_next  = '0;
            root_next = '0;
            iter_next = '0;
        end
        else if (cmd.root_step)
        begin
            rad_next  = rad_reg << 2;
            rem_next  = take ? rem_sub[REMW-1:0] : rem_sh[REMW-1:0];
            root_next = {root_reg[RW-2:0], take};
            iter_next = iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
    end

    // Output register; it holds while the receiver stalls.
    logic        out_valid_reg;
    logic [24:0] distance_reg;
    status_t     status_reg;
    logic [6:0]  point_count_reg;

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            distance_reg    <= 25'(root_reg);
            status_reg      <= res_status_reg;
            point_count_reg <= 7'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign distance    = distance_reg;
    assign status      = status_reg;
    assign point_count = point_count_reg;

    // The count never runs past the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table size");

    // A successful append advances the count by exactly one.
    a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("append did not advance the count");

endmodule

### design/point_store_euclidean_distance.sv
// ----------------------------------------------------------------------------
// point_store_euclidean_distance: point table with distance queries
// Appends signed points to a table and returns the fixed-point Euclidean
// distance between two stored points.
// ----------------------------------------------------------------------------
// Usage. Both channels use valid and stall; a transaction moves at a rising
// edge where valid is high and stall is low. Each input transaction gives
// exactly one output transaction: append (status full when the table holds
// MAX_POINTS points), query (status bad index when either index is at or
// beyond the count; distance zero then) or clear. Request code 3 is ignored.
// Distance is floor(sqrt(dx^2 + dy^2) * 2^FRAC_BITS).
// Append, clear and rejected queries pass from decode straight to the hand-off to
// the output register. A valid query first passes through the difference, the
// squaring of dx and dy and the square root, which produces one result bit per
// cycle. The hand-off waits until the output register is free.
// One transaction is worked on at a time; the next one is accepted while a
// finished result waits in the output register. When the receiver stalls, the
// result holds and a following result waits inside the block.
// Reset empties the table; stored coordinates are not cleared.
// ----------------------------------------------------------------------------
module point_store_euclidean_distance
    import psed_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic        [1:0]  req_type,
    input  logic signed [15:0] x_coord,
    input  logic signed [15:0] y_coord,
    input  logic        [5:0]  first_index,
    input  logic        [5:0]  second_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [24:0] distance,
    output logic        [1:0]  status,
    output logic        [6:0]  point_count
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    psed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table, arithmetic and output register.
    psed_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .first_index  (first_index),
        .second_index (second_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .status       (status),
        .point_count  (point_count),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
